FILE: src/atrlc_pkg.sv
package atrlc_pkg;

  localparam int unsigned MaxLineLength = 255;
  localparam int unsigned LenCapInt     = (MaxLineLength < 255) ? MaxLineLength : 255;
  localparam logic [7:0]  LenCap        = LenCapInt[7:0];

  localparam int unsigned NumPatterns   = 6;
  localparam int unsigned PrefixPattern = 5;
  localparam int unsigned NumOkPatterns = 4;
  localparam int unsigned ErrorPattern  = 4;

  localparam logic [NumPatterns-1:0] AllAlive = '1;

  localparam logic [7:0] CharCr = 8'd13;
  localparam logic [7:0] CharLf = 8'd10;

  localparam logic [1:0] ClsOther = 2'd0;
  localparam logic [1:0] ClsOk    = 2'd1;
  localparam logic [1:0] ClsError = 2'd2;

  localparam logic [3:0] PatLen [NumPatterns] = '{4'd2, 4'd7, 4'd8, 4'd7, 4'd5, 4'd12};

  typedef struct packed {
    logic       present;
    logic [1:0] cls;
    logic [7:0] len;
    logic [1:0] verdict;
    logic       resp_end;
  } result_t;

  function automatic logic [7:0] pat_char(input logic [2:0] idx, input logic [3:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (idx)
      3'd0: begin
        unique case (pos)
          4'd0:    ch = "O";
          4'd1:    ch = "K";
          default: ch = 8'h00;
        endcase
      end
      3'd1: begin
        unique case (pos)
          4'd0:    ch = "S";
          4'd1:    ch = "E";
          4'd2:    ch = "N";
          4'd3:    ch = "D";
          4'd4:    ch = " ";
          4'd5:    ch = "O";
          4'd6:    ch = "K";
          default: ch = 8'h00;
        endcase
      end
      3'd2: begin
        unique case (pos)
          4'd0:    ch = "C";
          4'd1:    ch = "L";
          4'd2:    ch = "O";
          4'd3:    ch = "S";
          4'd4:    ch = "E";
          4'd5:    ch = " ";
          4'd6:    ch = "O";
          4'd7:    ch = "K";
          default: ch = 8'h00;
        endcase
      end
      3'd3: begin
        unique case (pos)
          4'd0:    ch = "S";
          4'd1:    ch = "H";
          4'd2:    ch = "U";
          4'd3:    ch = "T";
          4'd4:    ch = " ";
          4'd5:    ch = "O";
          4'd6:    ch = "K";
          default: ch = 8'h00;
        endcase
      end
      3'd4: begin
        unique case (pos)
          4'd0:    ch = "E";
          4'd1:    ch = "R";
          4'd2:    ch = "R";
          4'd3:    ch = "O";
          4'd4:    ch = "R";
          default: ch = 8'h00;
        endcase
      end
      3'd5: begin
        unique case (pos)
          4'd0:    ch = "+";
          4'd1:    ch = "C";
          4'd2:    ch = "M";
          4'd3:    ch = "E";
          4'd4:    ch = " ";
          4'd5:    ch = "E";
          4'd6:    ch = "R";
          4'd7:    ch = "R";
          4'd8:    ch = "O";
          4'd9:    ch = "R";
          4'd10:   ch = ":";
          4'd11:   ch = " ";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

FILE: src/atrlc_char_step.sv
module atrlc_char_step (
  input  logic [atrlc_pkg::NumPatterns-1:0] alive_i,
  input  logic [7:0]                        len_i,
  input  logic [7:0]                        char_i,
  output logic [atrlc_pkg::NumPatterns-1:0] alive_o,
  output logic [7:0]                        len_o
);
  import atrlc_pkg::*;

  for (genvar i = 0; i < NumPatterns; i++) begin : g_pat
    logic in_pat;
    assign in_pat = len_i < {4'd0, PatLen[i]};
    if (i == PrefixPattern) begin : g_prefix
      // past the end of the prefix everything matches
      assign alive_o[i] = alive_i[i] && (!in_pat || (pat_char(3'(i), len_i[3:0]) == char_i));
    end else begin : g_exact
      assign alive_o[i] = alive_i[i] && in_pat && (pat_char(3'(i), len_i[3:0]) == char_i);
    end
  end

  assign len_o = (len_i < LenCap) ? len_i + 8'd1 : LenCap;

endmodule

FILE: src/atrlc_line_ctrl.sv
module atrlc_line_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [7:0]        data_i,
  input  logic              last_i,
  output atrlc_pkg::result_t result_o
);
  import atrlc_pkg::*;

  logic [NumPatterns-1:0] alive_q, alive_d;
  logic [7:0]             len_q, len_d;
  logic                   cr_q, cr_d;
  logic                   open_q, open_d;
  logic [1:0]             verdict_q, verdict_d;

  logic                   is_cr, is_lf, close_crlf, a_en, b_en, open_after, closed;
  logic [7:0]             char_b;
  logic [NumPatterns-1:0] alive_a_step, alive_a, alive_b_step, alive_b;
  logic [7:0]             len_a_step, len_a, len_b_step, len_b;
  logic [1:0]             cls, verdict_new;
  logic                   ok_hit;

  assign is_cr      = data_i == CharCr;
  assign is_lf      = data_i == CharLf;
  assign close_crlf = cr_q && is_lf;
  // a held CR that is not followed by LF becomes part of the line
  assign a_en       = cr_q && !is_lf;
  // a CR on the last byte cannot wait for its LF
  assign b_en       = !close_crlf && (!is_cr || last_i);
  assign char_b     = is_cr ? CharCr : data_i;

  atrlc_char_step u_step_a (
    .alive_i (alive_q),
    .len_i   (len_q),
    .char_i  (CharCr),
    .alive_o (alive_a_step),
    .len_o   (len_a_step)
  );

  assign alive_a = a_en ? alive_a_step : alive_q;
  assign len_a   = a_en ? len_a_step : len_q;

  atrlc_char_step u_step_b (
    .alive_i (alive_a),
    .len_i   (len_a),
    .char_i  (char_b),
    .alive_o (alive_b_step),
    .len_o   (len_b_step)
  );

  assign alive_b    = b_en ? alive_b_step : alive_a;
  assign len_b      = b_en ? len_b_step : len_a;
  assign open_after = open_q || a_en || b_en;
  assign closed     = close_crlf || (last_i && open_after);

  always_comb begin
    ok_hit = 1'b0;
    for (int i = 0; i < NumOkPatterns; i++) begin
      if (alive_b[i] && len_b == {4'd0, PatLen[i]}) begin
        ok_hit = 1'b1;
      end
    end
    priority if (ok_hit) begin
      cls = ClsOk;
    end else if (alive_b[ErrorPattern] && len_b == {4'd0, PatLen[ErrorPattern]}) begin
      cls = ClsError;
    end else if (alive_b[PrefixPattern] && len_b >= {4'd0, PatLen[PrefixPattern]}) begin
      cls = ClsError;
    end else begin
      cls = ClsOther;
    end
  end

  assign verdict_new = (verdict_q == ClsOther) ? cls : verdict_q;

  always_comb begin
    alive_d   = alive_q;
    len_d     = len_q;
    cr_d      = cr_q;
    open_d    = open_q;
    verdict_d = verdict_q;
    if (en_i) begin
      if (closed) begin
        alive_d   = AllAlive;
        len_d     = 8'd0;
        cr_d      = 1'b0;
        open_d    = 1'b0;
        verdict_d = last_i ? ClsOther : verdict_new;
      end else begin
        alive_d = alive_b;
        len_d   = len_b;
        cr_d    = is_cr && !last_i;
        open_d  = open_after;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q   <= AllAlive;
      len_q     <= 8'd0;
      cr_q      <= 1'b0;
      open_q    <= 1'b0;
      verdict_q <= ClsOther;
    end else begin
      alive_q   <= alive_d;
      len_q     <= len_d;
      cr_q      <= cr_d;
      open_q    <= open_d;
      verdict_q <= verdict_d;
    end
  end

  assign result_o.present  = closed;
  assign result_o.cls      = cls;
  assign result_o.len      = len_b;
  assign result_o.verdict  = verdict_new;
  assign result_o.resp_end = last_i;

  assert property (@(posedge clk_i) disable iff (!rst_ni) cr_q |-> !open_q || len_q != 8'd0)
    else $error("held CR with an open line of zero length");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !open_q |-> len_q == 8'd0 && alive_q == AllAlive)
    else $error("closed line keeps match state");
  assert property (@(posedge clk_i) disable iff (!rst_ni) en_i && last_i |=> !cr_q && !open_q && verdict_q == ClsOther)
    else $error("response end did not clear line state");

endmodule

FILE: src/at_response_line_classifier.sv
// AT response line classifier.
// Input channel (in_valid_i / in_ready_o) takes one response byte per request,
// with last_byte_i marking the final byte of a response. The output channel
// (out_valid_o / out_ready_i) carries one request per closed line: its class,
// its length without CR LF (saturating), the sticky verdict of the response
// and a flag for the end of the response. Bytes that close no line give no
// output request.
// Path: a taken byte waits in the input register and is matched from there;
// its result is captured in the output register, which drives out_valid_o.
// Throughput: one byte per cycle while the output is not stalled; the matcher
// updates six pattern bits and the length counter in one combinational step,
// applied at most twice per byte.
// Reset: line state, held CR and verdict are cleared; both valids drop.
// Stall: while a result waits in the output register, the input register still
// advances when the byte it holds gives no result; otherwise it holds and
// in_ready_o drops once both registers are full.
module at_response_line_classifier (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       line_present_o,
  output logic [1:0] line_class_o,
  output logic [7:0] line_length_o,
  output logic [1:0] response_verdict_o,
  output logic       response_end_o
);
  import atrlc_pkg::*;

  logic       in_valid_q;
  logic [7:0] data_q;
  logic       last_q;
  logic       out_valid_q;
  result_t    res_q;
  result_t    res;
  logic       advance;
  logic       in_take;

  // advance the held byte when the output slot is free or being emptied,
  // or when it produces nothing
  assign advance = in_valid_q && (!out_valid_q || out_ready_i || !res.present);
  assign in_ready_o = !in_valid_q || advance;
  assign in_take = in_valid_i && in_ready_o;

  atrlc_line_ctrl u_line_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .data_i   (data_q),
    .last_i   (last_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance && res.present) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      data_q <= data_byte_i;
      last_q <= last_byte_i;
    end
    if (advance && res.present) begin
      res_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign line_present_o     = res_q.present;
  assign line_class_o       = res_q.cls;
  assign line_length_o      = res_q.len;
  assign response_verdict_o = res_q.verdict;
  assign response_end_o     = res_q.resp_end;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o |-> line_class_o == ClsOther || line_class_o == ClsOk ||
                                   line_class_o == ClsError)
    else $error("undefined line class");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && line_class_o != ClsOther |-> response_verdict_o != ClsOther)
    else $error("decisive line left verdict unknown");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o |-> line_length_o <= LenCap)
    else $error("line length above cap");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a full output register");

endmodule
